[hw/rtl/regular_timestamp_batcher_unit_macros.svh]
// Assertion macros shared by the batcher RTL.
`ifndef REGULAR_TIMESTAMP_BATCHER_UNIT_MACROS_SVH
`define REGULAR_TIMESTAMP_BATCHER_UNIT_MACROS_SVH

// Clocked check, off while reset is held.
`define RTB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rtb_pkg.sv]
// Shared constants and types of the timestamp batcher.
package rtb_pkg;

    // Widths fixed by the word format
    localparam int TS_W       = 64;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Defaults
    localparam int MAX_CAPACITY_LOG2_DEF = 16;
    localparam int CAPACITY_LOG2_RESET   = 6;
    localparam int QUEUE_DEPTH_DEF       = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGULAR_MODE  = 1'b0,
        CFG_CAPACITY_LOG2 = 1'b1
    } t_cfg_idx;

    // Input word kinds
    typedef enum logic [0:0] {
        MODE_SAMPLE = 1'b0,
        MODE_END    = 1'b1
    } t_in_mode;

endpackage

[hw/rtl/rtb_front.sv]
// Front end: holds batch state, classifies each word and builds its result.
`include "regular_timestamp_batcher_unit_macros.svh"

module rtb_front #(
    parameter int MAX_CAPACITY_LOG2 = rtb_pkg::MAX_CAPACITY_LOG2_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_valid,
    input  logic [rtb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rtb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // accepted input word
    input  logic                               i_accept,
    input  logic                               i_mode,
    input  logic [rtb_pkg::TS_W-1:0]           i_timestamp,
    input  logic [rtb_pkg::WORD_W-1:0]         i_sample_word,
    // result word for the queue
    output logic                               o_closed,
    output logic [rtb_pkg::TS_W-1:0]           o_closed_start,
    output logic [rtb_pkg::TS_W-1:0]           o_closed_period,
    output logic [MAX_CAPACITY_LOG2:0]         o_closed_count,
    output logic [MAX_CAPACITY_LOG2-1:0]       o_slot_index,
    output logic [rtb_pkg::WORD_W-1:0]         o_slot_word,
    output logic                               o_complete
);

    localparam int CW = MAX_CAPACITY_LOG2 + 1;
    localparam int SW = MAX_CAPACITY_LOG2;
    localparam int TW = rtb_pkg::TS_W;
    localparam logic [rtb_pkg::CFG_DATA_W-1:0] CAP_MAX =
        rtb_pkg::CFG_DATA_W'(MAX_CAPACITY_LOG2);
    localparam int CAP_RST_EFF = (rtb_pkg::CAPACITY_LOG2_RESET > MAX_CAPACITY_LOG2) ?
        MAX_CAPACITY_LOG2 : rtb_pkg::CAPACITY_LOG2_RESET;
    localparam logic [CW-1:0] LIMIT_RST = CW'(1) << CAP_RST_EFF;

    logic          r_regular;
    logic [CW-1:0] r_limit;
    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_start, n_start;
    logic [TW-1:0] r_delta, n_delta;
    logic [TW-1:0] r_expect, n_expect;

    logic                           batch_open, at_limit, multi, ts_miss;
    logic                           close_smp, is_end;
    logic [CW-1:0]                  base;
    logic [rtb_pkg::CFG_DATA_W-1:0] cap_eff;

    // Config registers; capacity kept as the saturated batch size
    assign cap_eff = (i_cfg_data > CAP_MAX) ? CAP_MAX : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regular <= 1'b0;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (rtb_pkg::t_cfg_idx'(i_cfg_index))
                rtb_pkg::CFG_REGULAR_MODE:  r_regular <= i_cfg_data[0];
                rtb_pkg::CFG_CAPACITY_LOG2: r_limit   <= CW'(1) << cap_eff;
                default: ;
            endcase
        end
    end

    // Classify: does this word close the open batch
    assign is_end     = (rtb_pkg::t_in_mode'(i_mode) == rtb_pkg::MODE_END);
    assign batch_open = (r_count != '0);
    assign at_limit   = (r_count >= r_limit);
    assign multi      = (r_count > CW'(1));
    assign ts_miss    = (i_timestamp != r_expect);
    assign close_smp  = batch_open && (!r_regular || at_limit || (multi && ts_miss));

    // Slot of a sample after any close
    assign base = close_smp ? '0 : r_count;

    // Result word
    always_comb begin
        o_closed        = is_end ? batch_open : close_smp;
        o_closed_start  = o_closed ? r_start : '0;
        o_closed_period = (o_closed && multi) ? r_delta : '0;
        o_closed_count  = o_closed ? r_count : '0;
        o_slot_index    = is_end ? '0 : base[SW-1:0];
        o_slot_word     = is_end ? '0 : i_sample_word;
        o_complete      = is_end;
    end

    // Next batch state; expected time runs as start + count*delta
    always_comb begin
        n_count  = r_count;
        n_start  = r_start;
        n_delta  = r_delta;
        n_expect = r_expect;
        if (is_end) begin
            n_count  = '0;
            n_start  = '0;
            n_delta  = '0;
            n_expect = '0;
        end else begin
            n_count = base + CW'(1);
            if (base == '0) begin
                n_start = i_timestamp;
            end else if (base == CW'(1)) begin
                n_delta  = i_timestamp - r_start;
                n_expect = {i_timestamp[TW-2:0], 1'b0} - r_start;
            end else begin
                n_expect = r_expect + r_delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_start  <= n_start;
            r_delta  <= n_delta;
            r_expect <= n_expect;
        end
    end

    `RTB_ASSERT(a_end_empties, i_clk, i_rst_n, (i_accept && is_end) |=> (r_count == '0), "end word left a batch open")
    `RTB_ASSERT(a_sample_fills, i_clk, i_rst_n, (i_accept && !is_end) |=> (r_count != '0), "sample word left batch empty")
    `RTB_ASSERT(a_irregular_single, i_clk, i_rst_n, (i_accept && !is_end && !r_regular) |=> (r_count == CW'(1)), "irregular sample not alone")

endmodule

[hw/rtl/rtb_queue.sv]
// Result queue between the front end and the output side.
`include "regular_timestamp_batcher_unit_macros.svh"

module rtb_queue #(
    parameter int W     = 8,
    parameter int DEPTH = rtb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Pointer wrap
    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `RTB_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= NW'(DEPTH), "queue count past depth")
    `RTB_ASSERT(a_push_shows, i_clk, i_rst_n, (do_push && !do_pop) |=> !o_empty, "pushed word not visible")

endmodule

[hw/rtl/regular_timestamp_batcher_unit.sv]
// Top level of the timestamp batcher: front end plus result queue.
// Takes one word per clock while full is low: a sample or an end-of-stream marker. Each
// accepted word yields exactly one result word, visible on the result ports the cycle
// after it is taken if the queue was empty, else once earlier results are popped. The
// front end updates count, start, period and a running expected time per accepted word;
// a four-word result queue lets the output stall independently; full rises only when four
// results wait. Config writes are taken every cycle and apply from the next input word.
`include "regular_timestamp_batcher_unit_macros.svh"

module regular_timestamp_batcher_unit #(
    parameter int MAX_CAPACITY_LOG2 = rtb_pkg::MAX_CAPACITY_LOG2_DEF,
    parameter int QUEUE_DEPTH       = rtb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rtb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input side
    input  logic                           push,
    output logic                           full,
    input  logic                           i_mode,
    input  logic [rtb_pkg::TS_W-1:0]       i_timestamp,
    input  logic [rtb_pkg::WORD_W-1:0]     i_sample_word,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_closed,
    output logic [rtb_pkg::TS_W-1:0]       o_closed_start,
    output logic [rtb_pkg::TS_W-1:0]       o_closed_period,
    output logic [MAX_CAPACITY_LOG2:0]     o_closed_count,
    output logic [MAX_CAPACITY_LOG2-1:0]   o_slot_index,
    output logic [rtb_pkg::WORD_W-1:0]     o_slot_word,
    output logic                           o_complete
);

    localparam int RW = 1 + 2 * rtb_pkg::TS_W + (MAX_CAPACITY_LOG2 + 1) + MAX_CAPACITY_LOG2
                        + rtb_pkg::WORD_W + 1;

    logic                         accept;
    logic                         f_closed, f_complete;
    logic [rtb_pkg::TS_W-1:0]     f_start, f_period;
    logic [MAX_CAPACITY_LOG2:0]   f_count;
    logic [MAX_CAPACITY_LOG2-1:0] f_slot;
    logic [rtb_pkg::WORD_W-1:0]   f_word;
    logic [RW-1:0]                q_in, q_out;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    rtb_front #(
        .MAX_CAPACITY_LOG2 (MAX_CAPACITY_LOG2)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_mode          (i_mode),
        .i_timestamp     (i_timestamp),
        .i_sample_word   (i_sample_word),
        .o_closed        (f_closed),
        .o_closed_start  (f_start),
        .o_closed_period (f_period),
        .o_closed_count  (f_count),
        .o_slot_index    (f_slot),
        .o_slot_word     (f_word),
        .o_complete      (f_complete)
    );

    // Pack result word
    assign q_in = {f_closed, f_start, f_period, f_count, f_slot, f_word, f_complete};

    rtb_queue #(
        .W     (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign {o_closed, o_closed_start, o_closed_period, o_closed_count,
            o_slot_index, o_slot_word, o_complete} = q_out;

    `RTB_ASSERT(a_rst_empty, i_clk, i_rst_n, $rose(i_rst_n) |-> empty, "results present right after reset")
    `RTB_ASSERT(a_not_both, i_clk, i_rst_n, !(full && empty), "queue full and empty at once")

endmodule

[sim/regular_timestamp_batcher_checker.sv]
// Checker for the timestamp batcher: tracks batch state and compares every result word.
`timescale 1ns / 100ps

module regular_timestamp_batcher_checker #(
    parameter int MAX_CAPACITY_LOG2 = rtb_pkg::MAX_CAPACITY_LOG2_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration channel
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [rtb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input side
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic                           i_mode,
    input  logic [rtb_pkg::TS_W-1:0]       i_timestamp,
    input  logic [rtb_pkg::WORD_W-1:0]     i_sample_word,
    // result side
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic                           i_closed,
    input  logic [rtb_pkg::TS_W-1:0]       i_closed_start,
    input  logic [rtb_pkg::TS_W-1:0]       i_closed_period,
    input  logic [MAX_CAPACITY_LOG2:0]     i_closed_count,
    input  logic [MAX_CAPACITY_LOG2-1:0]   i_slot_index,
    input  logic [rtb_pkg::WORD_W-1:0]     i_slot_word,
    input  logic                           i_complete,
    // status for the testbench top
    output int                             o_fail_count,
    output int                             o_pending
);
    import rtb_pkg::*;

    typedef struct packed {
        logic                         closed;
        logic [TS_W-1:0]              start;
        logic [TS_W-1:0]              period;
        logic [MAX_CAPACITY_LOG2:0]   count;
        logic [MAX_CAPACITY_LOG2-1:0] slot;
        logic [WORD_W-1:0]            word;
        logic                         complete;
    } batch_result_t;

    // Shadow copy of the configuration registers
    logic                  cfg_regular;
    logic [CFG_DATA_W-1:0] cfg_cap_log2;

    // Shadow copy of the open batch
    logic [MAX_CAPACITY_LOG2:0] run_count;
    logic [TS_W-1:0]            run_start;
    logic [TS_W-1:0]            run_step;
    logic                       step_known;

    batch_result_t expected_q[$];
    int            mismatch_total = 0;
    int            pending_words  = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = pending_words;

    // Works out the result word of one input word and advances the shadow batch
    function automatic batch_result_t predict_batch_result(logic mode, logic [TS_W-1:0] ts,
                                                           logic [WORD_W-1:0] word);
        batch_result_t r;
        int unsigned   cap_exp;
        logic [TS_W-1:0] next_ts;
        logic          closing;
        r       = '0;
        cap_exp = (cfg_cap_log2 > MAX_CAPACITY_LOG2) ? MAX_CAPACITY_LOG2 : cfg_cap_log2;
        // expected time of the next sample, modulo 2^64
        next_ts = run_start + TS_W'(run_count) * run_step;
        if (mode == MODE_END) begin
            closing = (run_count != 0);
        end else begin
            closing = (run_count != 0) &&
                      (!cfg_regular ||
                       TS_W'(run_count) >= (TS_W'(1) << cap_exp) ||
                       (run_count > 1 && ts != next_ts));
        end
        if (closing) begin
            r.closed = 1'b1;
            r.start  = run_start;
            r.period = step_known ? run_step : '0;
            r.count  = run_count;
        end
        if (mode == MODE_END) begin
            // flush: everything back to empty
            r.complete = 1'b1;
            run_count  = '0;
            run_start  = '0;
            run_step   = '0;
            step_known = 1'b0;
        end else begin
            if (closing) begin
                run_count  = '0;
                step_known = 1'b0;
            end
            if (run_count == 0) begin
                run_start  = ts;
                step_known = 1'b0;
            end else if (run_count == 1) begin
                run_step   = ts - run_start;
                step_known = 1'b1;
            end
            r.slot    = run_count[MAX_CAPACITY_LOG2-1:0];
            r.word    = word;
            run_count = run_count + 1'b1;
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic [TS_W-1:0] want,
                                          logic [TS_W-1:0] got);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("%0t: result %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function automatic void check_field(string what, logic [TS_W-1:0] want,
                                        logic [TS_W-1:0] got);
        if (got !== want)
            note_mismatch(what, want, got);
    endfunction

    // Watch the three channels; pops are matched before this edge's push is queued
    always @(posedge i_clk) begin
        batch_result_t want;
        if (!i_rst_n) begin
            cfg_regular  = 1'b0;
            cfg_cap_log2 = CFG_DATA_W'(CAPACITY_LOG2_RESET);
            run_count    = '0;
            run_start    = '0;
            run_step     = '0;
            step_known   = 1'b0;
            expected_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    note_mismatch("word with none expected", '0, TS_W'(i_slot_word));
                end else begin
                    want = expected_q.pop_front();
                    check_field("closed", TS_W'(want.closed), TS_W'(i_closed));
                    check_field("closed_start", want.start, i_closed_start);
                    check_field("closed_period", want.period, i_closed_period);
                    check_field("closed_count", TS_W'(want.count), TS_W'(i_closed_count));
                    check_field("slot_index", TS_W'(want.slot), TS_W'(i_slot_index));
                    check_field("slot_word", TS_W'(want.word), TS_W'(i_slot_word));
                    check_field("complete", TS_W'(want.complete), TS_W'(i_complete));
                end
            end
            if (i_push && !i_full)
                expected_q.push_back(predict_batch_result(i_mode, i_timestamp, i_sample_word));
            // a write applies from the next input word
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_REGULAR_MODE:  cfg_regular  = i_cfg_data[0];
                    CFG_CAPACITY_LOG2: cfg_cap_log2 = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_words = expected_q.size();
    end

endmodule

[sim/regular_timestamp_batcher_unit_tb.sv]
// Testbench top for the timestamp batcher: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps

module regular_timestamp_batcher_unit_tb;
    import rtb_pkg::*;

    localparam int MAX_CAP       = MAX_CAPACITY_LOG2_DEF;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 80;
    localparam int ITEMS_PER_SET = 183;
    localparam int WORDS_PER_CFG = 45;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    logic                  in_mode;
    logic [TS_W-1:0]       in_timestamp;
    logic [WORD_W-1:0]     in_word;
    logic                  empty;
    logic                  pop;
    logic                  res_closed;
    logic [TS_W-1:0]       res_start;
    logic [TS_W-1:0]       res_period;
    logic [MAX_CAP:0]      res_count;
    logic [MAX_CAP-1:0]    res_slot;
    logic [WORD_W-1:0]     res_word;
    logic                  res_complete;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 23;
    int   recv_idle_pct = 71;
    logic hold_req = 1'b0;

    regular_timestamp_batcher_unit #(
        .MAX_CAPACITY_LOG2 (MAX_CAP)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .push            (push),
        .full            (full),
        .i_mode          (in_mode),
        .i_timestamp     (in_timestamp),
        .i_sample_word   (in_word),
        .empty           (empty),
        .pop             (pop),
        .o_closed        (res_closed),
        .o_closed_start  (res_start),
        .o_closed_period (res_period),
        .o_closed_count  (res_count),
        .o_slot_index    (res_slot),
        .o_slot_word     (res_word),
        .o_complete      (res_complete)
    );

    regular_timestamp_batcher_checker #(
        .MAX_CAPACITY_LOG2 (MAX_CAP)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_push          (push),
        .i_full          (full),
        .i_mode          (in_mode),
        .i_timestamp     (in_timestamp),
        .i_sample_word   (in_word),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_closed        (res_closed),
        .i_closed_start  (res_start),
        .i_closed_period (res_period),
        .i_closed_count  (res_count),
        .i_slot_index    (res_slot),
        .i_slot_word     (res_word),
        .i_complete      (res_complete),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random pops, plus one long hold-off on request
    initial begin
        int   hold_left;
        logic hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any word moving on any channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [TS_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Offer one word; returns at the edge where it was taken
    task automatic send_word(logic mode, logic [TS_W-1:0] ts, logic [WORD_W-1:0] word);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        in_mode      <= mode;
        in_timestamp <= ts;
        in_word      <= word;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_sample(logic [TS_W-1:0] ts, logic [WORD_W-1:0] word);
        send_word(MODE_SAMPLE, ts, word);
    endtask

    // End of stream; timestamp and word are don't-care, so keep them random
    task automatic send_end();
        send_word(MODE_END, rand64(), $urandom());
    endtask

    // Stop offering and wait until every expected word has been popped
    task automatic drain_results();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Both registers, back to back, with the block idle
    task automatic write_config(logic regular, logic [CFG_DATA_W-1:0] cap_log2);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_REGULAR_MODE;
        cfg_data  <= CFG_DATA_W'(regular);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_index <= CFG_CAPACITY_LOG2;
        cfg_data  <= cap_log2;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_random_config();
        logic [CFG_DATA_W-1:0] cap;
        case ($urandom_range(9))
            0:       cap = CFG_DATA_W'(MAX_CAP);
            1:       cap = '1;
            2:       cap = CFG_DATA_W'($urandom_range(31));
            default: cap = CFG_DATA_W'($urandom_range(4));
        endcase
        write_config($urandom_range(99) < 80, cap);
    endtask

    function automatic logic [TS_W-1:0] pick_run_start();
        case ($urandom_range(3))
            0:       return rand64();
            1:       return '1 - TS_W'($urandom_range(50));
            2:       return TS_W'($urandom_range(1000));
            default: return {32'h0, $urandom()};
        endcase
    endfunction

    function automatic logic [TS_W-1:0] pick_run_step();
        case ($urandom_range(4))
            0:       return '0;
            1:       return TS_W'($urandom_range(1, 100));
            2:       return rand64();
            3:       return '0 - TS_W'($urandom_range(1, 100));
            default: return rand64() >> 16;
        endcase
    endfunction

    // Mostly evenly spaced runs, sometimes broken, sometimes stray words
    task automatic send_random_run(output int sent);
        logic [TS_W-1:0] first;
        logic [TS_W-1:0] step;
        logic [TS_W-1:0] ts;
        int              len;
        int              k;
        sent = 0;
        if ($urandom_range(99) < 15) begin
            if ($urandom_range(1))
                send_end();
            else
                send_sample(rand64(), $urandom());
            sent = 1;
        end else begin
            first = pick_run_start();
            step  = pick_run_step();
            len   = $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
                ts = first + TS_W'(k) * step;
                case ($urandom_range(24))
                    0:       ts = ts + TS_W'($urandom_range(1, 3));
                    1:       ts = rand64();
                    default: ;
                endcase
                send_sample(ts, $urandom());
            end
            sent = len;
            if ($urandom_range(99) < 30) begin
                send_end();
                sent++;
            end
        end
    endtask

    initial begin
        int sent;
        int set_total;
        int next_cfg;
        int idle_set;
        int k;
        i_rst_n      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_REGULAR_MODE;
        cfg_data     <= '0;
        push         <= 1'b0;
        in_mode      <= MODE_SAMPLE;
        in_timestamp <= '0;
        in_word      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: regular mode, four samples per batch
        write_config(1'b1, 5'd2);
        send_end();                                   // nothing open, completion only
        send_sample(64'd100, 32'hFFFF_FFFF);
        send_sample(64'd110, 32'h0);
        send_sample(64'd120, $urandom());
        send_sample(64'd130, $urandom());
        send_sample(64'd140, $urandom());             // batch full
        send_sample(64'd150, $urandom());
        send_sample(64'd175, $urandom());             // off the grid
        send_end();                                   // closes a one-sample batch
        // expected time wraps through 2^64
        send_sample(64'hFFFF_FFFF_FFFF_FFF5, $urandom());
        send_sample(64'hFFFF_FFFF_FFFF_FFFA, $urandom());
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, $urandom());
        send_sample(64'h0000_0000_0000_0004, $urandom());
        // falling timestamps: the delta itself wraps
        send_sample(64'd1000, $urandom());
        send_sample(64'd400, $urandom());
        send_sample(64'hFFFF_FFFF_FFFF_FF38, $urandom());
        // widen the batch while one is open
        write_config(1'b1, CFG_DATA_W'(MAX_CAP));
        send_sample(64'hFFFF_FFFF_FFFF_FCE0, $urandom());
        send_end();
        // zero spacing, then shrink capacity under the open batch
        send_sample(64'd10, $urandom());
        send_sample(64'd10, $urandom());
        send_sample(64'd10, $urandom());
        write_config(1'b1, 5'd1);
        send_sample(64'd10, $urandom());
        // irregular mode, capacity above range
        write_config(1'b0, 5'd31);
        send_sample(64'd0, 32'hFFFF_FFFF);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        // single-sample batches by capacity
        write_config(1'b1, 5'd0);
        send_sample(64'd7, $urandom());
        send_sample(64'd7, $urandom());

        // Random part in three idling settings
        for (idle_set = 0; idle_set < 3; idle_set++) begin
            case (idle_set)
                0: begin send_idle_pct = 23; recv_idle_pct = 71; end
                1: begin send_idle_pct = 71; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            set_total = 0;
            next_cfg  = 0;
            while (set_total < ITEMS_PER_SET) begin
                if (set_total >= next_cfg) begin
                    write_random_config();
                    next_cfg = set_total + WORDS_PER_CFG;
                end
                send_random_run(sent);
                set_total += sent;
                // long result stall while the input keeps pushing
                if (idle_set == 2 && !hold_req && set_total > 60) begin
                    hold_req <= 1'b1;
                    for (k = 0; k < 4; k++) begin
                        send_random_run(sent);
                        set_total += sent;
                    end
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[regular_timestamp_batcher_unit.f]
+incdir+hw/rtl
hw/rtl/rtb_pkg.sv
hw/rtl/rtb_front.sv
hw/rtl/rtb_queue.sv
hw/rtl/regular_timestamp_batcher_unit.sv
sim/regular_timestamp_batcher_checker.sv
sim/regular_timestamp_batcher_unit_tb.sv
